### rtl/core/gccc_pkg.sv
// Shared types and constants of the grid cell clearance classifier.
package gccc_pkg;

  localparam int unsigned ADDR_W   = 12;            // occupancy map address
  localparam int unsigned MAP_SIZE = 1 << ADDR_W;   // occupancy map entries
  localparam int unsigned POS_W    = 14;            // row * cols + col, full grid
  localparam int unsigned DIM_W    = 7;             // cols, rows, run counts
  localparam int unsigned SIZE_W   = 10;            // cell width and height
  localparam int unsigned RAD_W    = 16;            // clearance radius
  localparam int unsigned DIST_W   = 18;            // size/2 + size * count
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 3'd4;

  // Commands carried on tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CLASS_OPEN     = 2'd0,
    CLASS_OCCUPIED = 2'd1,
    CLASS_SMALL    = 2'd2,
    CLASS_NO_PATH  = 2'd3
  } cell_class_t;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_S = 2'd1,
    DIR_W = 2'd2,
    DIR_E = 2'd3
  } dir_t;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_OWN   = 8'b0000_0100,
    ST_DIV   = 8'b0000_1000,
    ST_STEP  = 8'b0001_0000,
    ST_CHK   = 8'b0010_0000,
    ST_DIST  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

endpackage

### rtl/core/grid_cell_clearance_classifier_unit.sv
// Grid cell clearance classifier: occupancy map, run walker and class decision.
// Reset: synchronous rst restores the registers and then clears the 4096-entry
//   map, one entry a cycle, before the first beat is taken.
// Write beat: no result. Query beat on an occupied or off-grid cell: the
//   own-cell read is checked in ST_OWN and ST_OUT loads the result. Free cell:
//   a restoring divider splits the index into row and col, then the walker steps
//   north, south, west and east through the single map read port, and ST_DIST
//   turns the runs into distances for ST_OUT. One query is in flight at a time.
// A waiting result holds the next query's ST_OUT, and so the input, until taken.
module grid_cell_clearance_classifier_unit
  import gccc_pkg::*;
#(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [11:0] cell_index, [12] occupied
  input  logic                  s_tuser,   // [0] command
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [1:0] cell_class, [2] barrier,
                                           // [9:3] run_north, [16:10] run_south,
                                           // [23:17] run_west, [30:24] run_east
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]  grid_cols;
  logic [DIM_W-1:0]  grid_rows;
  logic [SIZE_W-1:0] cell_width;
  logic [SIZE_W-1:0] cell_height;
  logic [RAD_W-1:0]  clearance_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols        <= DIM_W'(64);
      grid_rows        <= DIM_W'(64);
      cell_width       <= SIZE_W'(10);
      cell_height      <= SIZE_W'(10);
      clearance_radius <= RAD_W'(30);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_COLS:   grid_cols        <= cfg_data[DIM_W-1:0];
        REG_GRID_ROWS:   grid_rows        <= cfg_data[DIM_W-1:0];
        REG_CELL_WIDTH:  cell_width       <= cfg_data[SIZE_W-1:0];
        REG_CELL_HEIGHT: cell_height      <= cfg_data[SIZE_W-1:0];
        REG_RADIUS:      clearance_radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the grid to the built maximum
  logic [DIM_W-1:0] cols_eff;
  logic [DIM_W-1:0] rows_eff;
  logic [POS_W-1:0] grid_cells;

  assign cols_eff = ({2'b00, grid_cols} > 9'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_cols;
  assign rows_eff = ({2'b00, grid_rows} > 9'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_rows;
  assign grid_cells = POS_W'(cols_eff) * POS_W'(rows_eff);

  // ---------------------------------------------------------------------------
  // Occupancy map: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic              map_mem [MAP_SIZE];
  logic              map_we;
  logic [ADDR_W-1:0] map_waddr;
  logic              map_wdata;
  logic              map_re;
  logic [ADDR_W-1:0] map_raddr;
  logic              map_rdata;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rdata <= map_mem[map_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------------
  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] q_idx;
  logic [ADDR_W-1:0] div_quo;     // dividend shifting out, quotient shifting in
  logic [DIM_W-1:0]  div_rem;
  logic [3:0]        div_cnt;
  logic [DIM_W-1:0]  org_row;
  logic [DIM_W-1:0]  org_col;
  logic [DIM_W-1:0]  pos_row;
  logic [DIM_W-1:0]  pos_col;
  logic [POS_W-1:0]  pos_addr;
  logic [DIM_W-1:0]  cand_row;
  logic [DIM_W-1:0]  cand_col;
  logic [POS_W-1:0]  cand_addr;
  dir_t              dir;
  logic [DIM_W-1:0]  run_cnt;
  logic [DIM_W-1:0]  runs [4];
  logic [DIST_W-1:0] reach [4];
  logic              res_occ;

  logic accept;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Restoring divider step
  logic [DIM_W:0]   rem_sh;
  logic             quo_bit;
  logic [DIM_W-1:0] rem_next;

  assign rem_sh   = {div_rem, div_quo[ADDR_W-1]};
  assign quo_bit  = (rem_sh >= {1'b0, cols_eff});
  assign rem_next = quo_bit ? DIM_W'(rem_sh - {1'b0, cols_eff}) : rem_sh[DIM_W-1:0];

  // Next cell in the current direction, and whether it lies in the grid and map
  logic             step_ok;
  logic [DIM_W-1:0] step_row;
  logic [DIM_W-1:0] step_col;
  logic [POS_W-1:0] step_addr;

  always_comb begin
    step_row  = pos_row;
    step_col  = pos_col;
    step_addr = pos_addr;
    step_ok   = 1'b0;
    unique case (dir)
      DIR_N: begin
        step_ok   = (pos_row != '0);
        step_row  = pos_row - 1'b1;
        step_addr = pos_addr - POS_W'(cols_eff);
      end
      DIR_S: begin
        step_ok   = ({1'b0, pos_row} + 1'b1) < {1'b0, rows_eff};
        step_row  = pos_row + 1'b1;
        step_addr = pos_addr + POS_W'(cols_eff);
      end
      DIR_W: begin
        step_ok   = (pos_col != '0);
        step_col  = pos_col - 1'b1;
        step_addr = pos_addr - 1'b1;
      end
      DIR_E: begin
        step_ok   = ({1'b0, pos_col} + 1'b1) < {1'b0, cols_eff};
        step_col  = pos_col + 1'b1;
        step_addr = pos_addr + 1'b1;
      end
      default: ;
    endcase
    // a cell beyond the map counts as blocked
    if (step_addr[POS_W-1:ADDR_W] != '0) begin
      step_ok = 1'b0;
    end
  end

  // Map port steering
  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_addr;
    map_wdata = 1'b0;
    map_re    = 1'b0;
    map_raddr = s_tdata[ADDR_W-1:0];
    if (state == ST_CLEAR) begin
      map_we = 1'b1;
    end else if (accept && (s_tuser == CMD_WRITE)) begin
      map_we    = 1'b1;
      map_waddr = s_tdata[ADDR_W-1:0];
      map_wdata = s_tdata[ADDR_W];
    end
    if (accept && (s_tuser == CMD_QUERY)) begin
      map_re = 1'b1;
    end else if ((state == ST_STEP) && step_ok) begin
      map_re    = 1'b1;
      map_raddr = step_addr[ADDR_W-1:0];
    end
  end

  // Class decision from the registered distances; later rules override
  logic [RAD_W-2:0]  half_rad;
  logic [DIST_W:0]   sum_ns;
  logic [DIST_W:0]   sum_we;
  cell_class_t       cls;

  assign half_rad = clearance_radius[RAD_W-1:1];
  assign sum_ns   = {1'b0, reach[DIR_N]} + {1'b0, reach[DIR_S]};
  assign sum_we   = {1'b0, reach[DIR_W]} + {1'b0, reach[DIR_E]};

  always_comb begin
    cls = CLASS_OPEN;
    if (res_occ) begin
      cls = CLASS_OCCUPIED;
    end else begin
      if (sum_ns < (DIST_W+1)'(clearance_radius)) cls = CLASS_SMALL;
      if ((reach[DIR_N] < DIST_W'(half_rad)) || (reach[DIR_S] < DIST_W'(half_rad))) begin
        cls = CLASS_NO_PATH;
      end
      if (sum_we < (DIST_W+1)'(clearance_radius)) cls = CLASS_SMALL;
      if ((reach[DIR_W] < DIST_W'(half_rad)) || (reach[DIR_E] < DIST_W'(half_rad))) begin
        cls = CLASS_NO_PATH;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Control sequence
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one loads in the same cycle
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          // sweep the map to free after reset
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MAP_SIZE - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (s_tuser == CMD_QUERY)) begin
            q_idx <= s_tdata[ADDR_W-1:0];
            state <= ST_OWN;
          end
        end
        ST_OWN: begin
          // own cell read is back: off grid or occupied ends the query here
          if ((cols_eff == '0) || (rows_eff == '0) ||
              ({2'b00, q_idx} >= grid_cells) || map_rdata) begin
            res_occ <= 1'b1;
            for (int i = 0; i < 4; i++) runs[i] <= '0;
            state <= ST_OUT;
          end else begin
            res_occ <= 1'b0;
            div_quo <= q_idx;
            div_rem <= '0;
            div_cnt <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_quo <= {div_quo[ADDR_W-2:0], quo_bit};
          div_rem <= rem_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 4'(ADDR_W - 1)) begin
            org_row  <= DIM_W'({div_quo[ADDR_W-2:0], quo_bit});
            org_col  <= rem_next;
            pos_row  <= DIM_W'({div_quo[ADDR_W-2:0], quo_bit});
            pos_col  <= rem_next;
            pos_addr <= {2'b00, q_idx};
            dir      <= DIR_N;
            run_cnt  <= DIM_W'(1);
            state    <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (step_ok) begin
            cand_row  <= step_row;
            cand_col  <= step_col;
            cand_addr <= step_addr;
            state     <= ST_CHK;
          end else begin
            // run ends at the grid or map edge: hold the count, restart from the origin
            runs[dir] <= run_cnt;
            pos_row   <= org_row;
            pos_col   <= org_col;
            pos_addr  <= {2'b00, q_idx};
            run_cnt   <= DIM_W'(1);
            dir       <= dir_t'(dir + 1'b1);
            state     <= (dir == DIR_E) ? ST_DIST : ST_STEP;
          end
        end
        ST_CHK: begin
          if (!map_rdata) begin
            // free neighbour: advance
            pos_row  <= cand_row;
            pos_col  <= cand_col;
            pos_addr <= cand_addr;
            run_cnt  <= run_cnt + 1'b1;
            state    <= ST_STEP;
          end else begin
            runs[dir] <= run_cnt;
            pos_row   <= org_row;
            pos_col   <= org_col;
            pos_addr  <= {2'b00, q_idx};
            run_cnt   <= DIM_W'(1);
            dir       <= dir_t'(dir + 1'b1);
            state     <= (dir == DIR_E) ? ST_DIST : ST_STEP;
          end
        end
        ST_DIST: begin
          reach[DIR_N] <= DIST_W'(cell_height[SIZE_W-1:1]) +
                          DIST_W'(cell_height) * DIST_W'(runs[DIR_N]);
          reach[DIR_S] <= DIST_W'(cell_height[SIZE_W-1:1]) +
                          DIST_W'(cell_height) * DIST_W'(runs[DIR_S]);
          reach[DIR_W] <= DIST_W'(cell_width[SIZE_W-1:1]) +
                          DIST_W'(cell_width) * DIST_W'(runs[DIR_W]);
          reach[DIR_E] <= DIST_W'(cell_width[SIZE_W-1:1]) +
                          DIST_W'(cell_width) * DIST_W'(runs[DIR_E]);
          state <= ST_OUT;
        end
        ST_OUT: begin
          // load the output register once the previous result has left
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, runs[DIR_E], runs[DIR_W], runs[DIR_S], runs[DIR_N],
                  (cls != CLASS_OPEN), cls};
    end
  end

endmodule
